@@ sv/f5d_pkg.sv @@
package f5d_pkg;

  localparam int unsigned TAPS     = 5;
  localparam int unsigned MAX_RES  = 5;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ACC_W    = 36;
  localparam int unsigned ROUND_SH = 16;

  // Largest window offset (newest position minus window start) that still
  // touches a live sample
  localparam int unsigned MAX_OFF  = 2 * (TAPS - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION   = CFG_IDX_W'(1);

  // Q0.16 taps 0.05, 0.2, 0.5, 0.2, 0.05
  localparam logic signed [16:0] TAP_Q16 [TAPS] = '{
    17'sd3277, 17'sd13107, 17'sd32768, 17'sd13107, 17'sd3277
  };

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // x[k] is the sample at block position n - k
  typedef sample_t [TAPS-1:0] xwin_t;

  typedef struct packed {
    logic       ok;   // window start lies within reach of the newest sample
    logic [3:0] off;  // newest position minus window start
  } tap_sel_t;

endpackage

@@ sv/f5d_tap_sum.sv @@
module f5d_tap_sum (
  input  f5d_pkg::xwin_t   x_i,
  input  f5d_pkg::tap_sel_t sel_i,
  output f5d_pkg::sample_t filtered_o
);

  logic signed [f5d_pkg::ACC_W-1:0] acc;
  logic signed [f5d_pkg::ACC_W-1:0] rounded;
  logic signed [f5d_pkg::ACC_W-1:0] scaled;

  always_comb begin
    logic [3:0] idx;
    logic signed [f5d_pkg::SAMPLE_W-1:0] xs;
    logic signed [f5d_pkg::SAMPLE_W+16:0] prod;
    acc = '0;
    for (int j = 0; j < f5d_pkg::TAPS; j++) begin
      idx = sel_i.off - 4'(j);
      xs  = '0;
      // tap j looks at sample start + j, i.e. x[off - j]
      if (sel_i.ok && (sel_i.off >= 4'(j)) && (idx <= 4'(f5d_pkg::TAPS - 1))) begin
        xs = x_i[idx[2:0]];
      end
      prod = xs * f5d_pkg::TAP_Q16[j];
      acc  = acc + f5d_pkg::ACC_W'(prod);
    end
  end

  // round half up, then floor shift
  assign rounded = acc + f5d_pkg::ACC_W'(1 << (f5d_pkg::ROUND_SH - 1));
  assign scaled  = rounded >>> f5d_pkg::ROUND_SH;

  always_comb begin
    if (scaled > f5d_pkg::ACC_W'(32767)) begin
      filtered_o = 16'sh7fff;
    end else if (scaled < -f5d_pkg::ACC_W'(32768)) begin
      filtered_o = 16'sh8000;
    end else begin
      filtered_o = scaled[f5d_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

@@ sv/fir5_decimator.sv @@
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: filtered, out_index; tlast; tuser
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One sample is taken per cycle while the item register is idle or finishing;
// a sample holds it until its R results are issued (at most 5, only the final
// sample of a block flushes several); a busy result register holds it longer.
// A result passes through the item register and then the result register.
// Reset clears the window, counters and config (length 1, decimation 1).
// A stall on m_axis holds the result register and backs up into s_axis.
module fir5_decimator #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] filtered, [31:16] out_index
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser,   // [0] block_done

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [f5d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [f5d_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = COUNT_WIDTH;
  // window start is output index times stride
  localparam int unsigned SW = COUNT_WIDTH + 8;
  localparam int unsigned WW = COUNT_WIDTH + 10;

  // configuration
  logic [15:0] sample_count_q;
  logic [7:0]  decimation_q;
  logic [CW-1:0] len;
  logic [CW-1:0] mdec;
  logic [7:0]  cfg_dec;
  logic        cfg_dec_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_dec     = (cfg_data_i[7:0] == 8'd0) ? 8'd1 : cfg_data_i[7:0];
  assign cfg_dec_wr  = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i == f5d_pkg::REG_DECIMATION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= 16'd1;
      decimation_q   <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        f5d_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[15:0];
        f5d_pkg::REG_DECIMATION:   decimation_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len  = CW'(sample_count_q);
    if (len == '0) len = CW'(1);
    mdec = CW'(decimation_q);
    if (mdec == '0) mdec = CW'(1);
  end

  // block front end: window and sample position
  f5d_pkg::sample_t [f5d_pkg::TAPS-2:0] win_q;
  logic [CW-1:0] scnt_q;
  logic          s_fire;
  logic          blk_last;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign blk_last = ({1'b0, scnt_q} + (CW+1)'(1)) >= {1'b0, len};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      scnt_q <= '0;
    end else if (s_fire) begin
      if (blk_last) begin
        win_q  <= '0;
        scnt_q <= '0;
      end else begin
        win_q  <= {win_q[f5d_pkg::TAPS-3:0], s_axis_tdata};
        scnt_q <= scnt_q + CW'(1);
      end
    end
  end

  // item register
  logic           busy_q;
  f5d_pkg::xwin_t x_q;
  logic [CW-1:0]  n_q;
  logic           last_q;
  logic [2:0]     cnt_q;
  logic [CW-1:0]  oc_q;
  logic [SW-1:0]  start_q;

  // emission control
  logic [WW-1:0] start_w, start2_w, m_w, len_w, n_w;
  logic          due, more, fire, finish, slot_free, done_flag;

  assign start_w  = WW'(start_q);
  assign m_w      = WW'(mdec);
  assign len_w    = WW'(len);
  assign n_w      = WW'(n_q);
  assign start2_w = start_w + m_w;

  always_comb begin
    due  = busy_q && (start2_w <= len_w) && (last_q || (start_w + WW'(4) <= n_w)) &&
           (cnt_q < 3'(f5d_pkg::MAX_RES));
    more = (start2_w + m_w <= len_w) && (last_q || (start2_w + WW'(4) <= n_w)) &&
           (cnt_q + 3'd1 < 3'(f5d_pkg::MAX_RES));
    done_flag = (start2_w + m_w) > len_w;
  end

  logic out_valid_q;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign fire          = due && slot_free;
  assign finish        = busy_q && (!due || (fire && !more));
  assign s_axis_tready = !busy_q || finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      last_q  <= 1'b0;
      cnt_q   <= '0;
      oc_q    <= '0;
      start_q <= '0;
      n_q     <= '0;
      x_q     <= '0;
    end else begin
      if (s_fire) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (s_fire) begin
        last_q <= blk_last;
        n_q    <= scnt_q;
        cnt_q  <= '0;
        x_q    <= {win_q, s_axis_tdata};
      end else if (fire) begin
        cnt_q  <= cnt_q + 3'd1;
      end
      if (finish && last_q) begin
        oc_q    <= '0;
        start_q <= '0;
      end else if (fire) begin
        oc_q    <= oc_q + CW'(1);
        start_q <= start_q + SW'(mdec);
      end else if (cfg_dec_wr) begin
        // a new stride rebases pending outputs unless a result issues this cycle
        start_q <= SW'(oc_q) * SW'(cfg_dec);
      end
    end
  end

  // filter datapath
  f5d_pkg::tap_sel_t sel;
  f5d_pkg::sample_t  filtered;
  logic [WW-1:0]     diff;

  assign diff    = n_w - start_w;
  assign sel.ok  = !diff[WW-1] && (diff <= WW'(f5d_pkg::MAX_OFF));
  assign sel.off = diff[3:0];

  f5d_tap_sum u_tap_sum (
    .x_i        (x_q),
    .sel_i      (sel),
    .filtered_o (filtered)
  );

  // result register
  logic [15:0] filt_q;
  logic [15:0] idx_q;
  logic        tlast_q;
  logic        tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      filt_q  <= filtered;
      idx_q   <= 16'(oc_q);
      tlast_q <= !more;
      tuser_q <= done_flag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {idx_q, filt_q};
  assign m_axis_tlast  = tlast_q;
  assign m_axis_tuser  = tuser_q;

  // checks
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(f5d_pkg::MAX_RES))
    else $error("result count per sample over cap");

  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> busy_q && slot_free)
    else $error("result issued without item or free slot");

  a_blk_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && last_q && !s_fire) |=> (oc_q == '0) && (start_q == '0))
    else $error("output counter not cleared at end of block");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && blk_last) |=> (scnt_q == '0))
    else $error("sample counter not cleared at end of block");

endmodule
